// ----- rtl/core/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers clocked on clk_i and disabled in reset;
// they compile to nothing when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check a property on every clock edge out of reset.
`define PMT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Check that post holds in the cycle after pre.
`define PMT_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) else $error(msg);
`else
`define PMT_ASSERT(lbl, prop, msg)
`define PMT_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

// ----- rtl/core/pmt_pkg.sv -----
// ----------------------------------------------------------------------------
// pmt_pkg
// Shared constants and types of the periodic match timer: counter width,
// mode codes and the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package pmt_pkg;

  // Width of the free-running counter (16 to 32)
  localparam int unsigned CounterWidth = 32;
  localparam int unsigned DivCntW      = $clog2(CounterWidth);
  localparam int unsigned StepW        = 16;
  localparam logic [StepW-1:0] StepCap = '1;

  typedef logic [CounterWidth-1:0] cnt_t;

  typedef enum logic [1:0] {
    MODE_READ    = 2'd0,
    MODE_ARM     = 2'd1,
    MODE_SERVICE = 2'd2,
    MODE_STOP    = 2'd3
  } mode_e;

  // Controller to datapath
  typedef struct packed {
    logic load_in;
    logic exec;
    logic div_start;
    logic ksum;
    logic mul;
    logic add;
    logic loop_step;
    logic load_out;
  } pmt_cmd_t;

  // Datapath to controller
  typedef struct packed {
    mode_e mode;
    logic  svc_short;
    logic  svc_skip;
    logic  div_busy;
    logic  loop_done;
  } pmt_status_t;

endpackage

// ----- rtl/core/pmt_divider.sv -----
// ----------------------------------------------------------------------------
// pmt_divider
// Restoring unsigned divider of CounterWidth-bit operands, one quotient bit
// per cycle. The divisor must be nonzero.
// ----------------------------------------------------------------------------
module pmt_divider import pmt_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  cnt_t dividend_i,
  input  cnt_t divisor_i,
  output logic busy_o,
  output cnt_t quotient_o
);

  logic               busy_q;
  logic [DivCntW-1:0] step_q;
  cnt_t               rem_q;
  cnt_t               quo_q;
  cnt_t               den_q;
  logic [CounterWidth:0] trial;
  logic               fits;

  // Trial subtract of the shifted remainder
  assign trial = {rem_q, quo_q[CounterWidth-1]} - {1'b0, den_q};
  assign fits  = !trial[CounterWidth];

  // Sequence the bit steps
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      step_q <= '0;
    end else if (busy_q) begin
      step_q <= step_q + 1'b1;
      if (step_q == DivCntW'(CounterWidth - 1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  // Shift remainder and quotient
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      den_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= fits ? trial[CounterWidth-1:0]
                    : {rem_q[CounterWidth-2:0], quo_q[CounterWidth-1]};
      quo_q <= {quo_q[CounterWidth-2:0], fits};
    end
  end

  assign busy_o     = busy_q;
  assign quotient_o = quo_q;

endmodule

// ----- rtl/core/pmt_ctrl.sv -----
// ----------------------------------------------------------------------------
// pmt_ctrl
// Controller of the periodic match timer: handshakes on both channels and
// sequences the datapath through execute, divide, step count, multiply, add and catch-up loop steps.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pmt_ctrl import pmt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  input  pmt_status_t status_i,
  output pmt_cmd_t    cmd_o
);

  typedef enum logic [7:0] {
    S_IDLE = 8'b00000001,
    S_EXEC = 8'b00000010,
    S_DIV  = 8'b00000100,
    S_KSUM = 8'b00001000,
    S_MUL  = 8'b00010000,
    S_ADD  = 8'b00100000,
    S_LOOP = 8'b01000000,
    S_FIN  = 8'b10000000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   is_service;

  assign is_service = (status_i.mode == MODE_SERVICE);

  // Decode commands from the state
  always_comb begin
    cmd_o           = '0;
    cmd_o.load_in   = (state_q == S_IDLE) && in_valid_i;
    cmd_o.exec      = (state_q == S_EXEC);
    cmd_o.div_start = (state_q == S_EXEC) && is_service && status_i.svc_short
                      && !status_i.svc_skip;
    cmd_o.ksum      = (state_q == S_KSUM);
    cmd_o.mul       = (state_q == S_MUL);
    cmd_o.add       = (state_q == S_ADD);
    cmd_o.loop_step = (state_q == S_LOOP);
    cmd_o.load_out  = (state_q == S_FIN) && (!out_valid_q || out_ready_i);
  end

  // Advance the state machine
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_EXEC;
      end
      S_EXEC: begin
        if (!is_service) begin
          state_d = S_FIN;
        end else if (!status_i.svc_short) begin
          state_d = S_LOOP;
        end else if (status_i.svc_skip) begin
          state_d = S_KSUM;
        end else begin
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        if (!status_i.div_busy) state_d = S_KSUM;
      end
      S_KSUM: state_d = S_MUL;
      S_MUL:  state_d = S_ADD;
      S_ADD:  state_d = S_FIN;
      S_LOOP: begin
        if (status_i.loop_done) state_d = S_FIN;
      end
      S_FIN: begin
        if (cmd_o.load_out) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Hold the result until the receiver takes it
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  // The divider finishes only while the controller waits on it
  `PMT_ASSERT(a_div_ends_in_div, $fell(status_i.div_busy) |-> state_q == S_DIV, "divider finished outside DIV")
  // A stalled result keeps the controller parked in FIN
  `PMT_ASSERT_NEXT(a_fin_waits, state_q == S_FIN && out_valid_q && !out_ready_i, state_q == S_FIN, "left FIN while output stalled")
  // An accepted transaction is executed on the next cycle
  `PMT_ASSERT_NEXT(a_accept_exec, in_valid_i && in_ready_o, state_q == S_EXEC, "accepted transaction not executed")

endmodule

// ----- rtl/core/pmt_dpath.sv -----
// ----------------------------------------------------------------------------
// pmt_dpath
// Datapath of the periodic match timer: timer state, read/arm/service/stop
// updates, closed-form catch-up (divide, multiply, add) and stepwise catch-up.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pmt_dpath import pmt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic [1:0]  mode_i,
  input  logic [31:0] counter_i,
  input  logic [30:0] delay_i,
  input  pmt_cmd_t    cmd_i,
  output pmt_status_t status_o,
  output logic [63:0] time_now_o,
  output logic [31:0] match_out_o,
  output logic        timer_on_o,
  output logic        match_pending_o,
  output logic [15:0] catchup_steps_o
);

  localparam int unsigned CW = CounterWidth;
  typedef logic [CW:0] ksum_t;

  // Configuration and latched transaction
  logic [31:0] min_delay_q;
  mode_e       mode_q;
  cnt_t        cnt_q;
  logic [30:0] dly_q;

  // Timer state
  logic [31:0] time_low_q, time_high_q, match_q, period_q;
  logic        enabled_q, pending_q;

  // Catch-up working registers
  cnt_t             p_q, diff_q, k_q, prod_q;
  logic             k_two_q, skip_q;
  logic [StepW-1:0] steps_q;

  // Result registers
  logic [63:0]      out_time_q;
  logic [31:0]      out_match_q;
  logic             out_on_q, out_pend_q;
  logic [StepW-1:0] out_steps_q;

  // Combinational terms
  cnt_t        p_now, d0, negd, cm_diff, arm_match, diff_nx, match_nx, div_quo;
  logic [CW:0] s_sum;
  logic        d0_pos, s_small, k_two, svc_short, svc_skip, time_wrap, div_busy;
  logic        loop_done;
  logic [31:0] arm_per;
  ksum_t       k_sum;
  logic [2*CW-1:0] prod_full;

  // Service setup: distance to the counter and the closed-form split
  assign p_now     = period_q[CW-1:0];
  assign d0        = match_q[CW-1:0] - cnt_q;
  assign d0_pos    = (d0 != '0) && !d0[CW-1];
  assign s_sum     = {1'b0, d0} + {1'b0, p_now};
  assign s_small   = (s_sum[CW:CW-1] == 2'b00);
  assign k_two     = d0_pos && !s_small;
  assign negd      = !d0_pos ? cnt_t'(-d0) : (s_small ? '0 : cnt_t'(-s_sum[CW-1:0]));
  assign svc_short = (p_now != '0) && !p_now[CW-1];
  assign svc_skip  = (negd < p_now);

  // Read and arm terms
  assign time_wrap = (32'(cnt_q) < time_low_q);
  assign cm_diff   = cnt_q - match_q[CW-1:0];
  assign arm_per   = (32'(dly_q) < min_delay_q) ? min_delay_q : 32'(dly_q);
  assign arm_match = arm_per[CW-1:0] + cnt_q;

  // Stepwise catch-up terms
  assign diff_nx   = diff_q + p_q;
  assign match_nx  = match_q[CW-1:0] + p_q;
  assign loop_done = ((diff_nx != '0) && !diff_nx[CW-1]) || (steps_q == StepCap - 1'b1);

  // Closed-form step count and product
  assign k_sum     = {1'b0, (skip_q ? '0 : div_quo)} + ksum_t'(k_two_q ? 2'd2 : 2'd1);
  assign prod_full = k_q * p_q;

  pmt_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (negd),
    .divisor_i  (p_now),
    .busy_o     (div_busy),
    .quotient_o (div_quo)
  );

  // Hold the minimum period
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_delay_q <= '0;
    end else if (cfg_we_i) begin
      min_delay_q <= cfg_wdata_i;
    end
  end

  // Latch the accepted transaction
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      mode_q <= mode_e'(mode_i);
      cnt_q  <= counter_i[CW-1:0];
      dly_q  <= delay_i;
    end
  end

  // Update the timer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_low_q  <= '0;
      time_high_q <= '0;
      match_q     <= '0;
      period_q    <= '0;
      enabled_q   <= 1'b0;
      pending_q   <= 1'b0;
    end else if (cmd_i.exec) begin
      unique case (mode_q)
        MODE_READ: begin
          time_low_q <= 32'(cnt_q);
          if (time_wrap) time_high_q <= time_high_q + 1'b1;
          if (enabled_q && !cm_diff[CW-1]) pending_q <= 1'b1;
        end
        MODE_ARM: begin
          pending_q <= 1'b0;
          if (dly_q != '0) begin
            period_q  <= arm_per;
            match_q   <= 32'(arm_match);
            enabled_q <= 1'b1;
          end
        end
        MODE_SERVICE: begin
          time_low_q <= 32'(cnt_q);
          if (time_wrap) time_high_q <= time_high_q + 1'b1;
          pending_q <= 1'b0;
        end
        MODE_STOP: begin
          enabled_q <= 1'b0;
          pending_q <= 1'b0;
          match_q   <= '0;
        end
        default: ;
      endcase
    end else if (cmd_i.loop_step) begin
      match_q <= 32'(match_nx);
    end else if (cmd_i.add) begin
      match_q <= 32'(match_q[CW-1:0] + prod_q);
    end
  end

  // Run the catch-up working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      p_q     <= p_now;
      diff_q  <= d0;
      k_two_q <= k_two;
      skip_q  <= svc_skip;
      steps_q <= '0;
    end else if (cmd_i.loop_step) begin
      diff_q  <= diff_nx;
      steps_q <= steps_q + 1'b1;
    end else if (cmd_i.ksum) begin
      k_q     <= k_sum[CW-1:0];
      steps_q <= (k_sum > ksum_t'(StepCap)) ? StepCap : k_sum[StepW-1:0];
    end
    if (cmd_i.mul) begin
      prod_q <= prod_full[CW-1:0];
    end
  end

  // Capture the result
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_time_q  <= {time_high_q, time_low_q};
      out_match_q <= match_q;
      out_on_q    <= enabled_q;
      out_pend_q  <= pending_q;
      out_steps_q <= steps_q;
    end
  end

  assign status_o.mode      = mode_q;
  assign status_o.svc_short = svc_short;
  assign status_o.svc_skip  = svc_skip;
  assign status_o.div_busy  = div_busy;
  assign status_o.loop_done = loop_done;

  assign time_now_o      = out_time_q;
  assign match_out_o     = out_match_q;
  assign timer_on_o      = out_on_q;
  assign match_pending_o = out_pend_q;
  assign catchup_steps_o = out_steps_q;

  // Only a service transaction reports catch-up steps
  `PMT_ASSERT(a_steps_zero, cmd_i.load_out && mode_q != MODE_SERVICE |-> steps_q == '0, "steps reported outside service")
  // Service always leaves pending cleared
  `PMT_ASSERT(a_svc_clears, cmd_i.load_out && mode_q == MODE_SERVICE |-> !pending_q, "pending left set after service")
  // Service ends with at least one period addition
  `PMT_ASSERT(a_svc_steps, cmd_i.load_out && mode_q == MODE_SERVICE |-> steps_q != '0, "service reported no steps")

endmodule

// ----- rtl/core/periodic_match_timer_with_catchup.sv -----
// ----------------------------------------------------------------------------
// periodic_match_timer_with_catchup
// Periodic match timer: extends a free-running counter to 64 bits, arms a
// periodic match, flags it pending and catches the match up on service.
// ----------------------------------------------------------------------------
// Usage:
//   Input transactions (valid/ready) carry mode, counter sample and delay;
//   each produces exactly one result transaction (valid/ready) with the
//   extended time, match value, enable, pending flag and catch-up step count.
//   The user writes min_delay (cfg_we_i/cfg_wdata_i) only while the block
//   is idle; the block does not enforce it. One transaction is worked at a
//   time; a new one is accepted once the previous result is in the output
//   register. Read, arm and stop go from execute straight to the result
//   register. Service with a period below half the counter range: step
//   count, multiply and add, after a bit-serial divide when the match is
//   at least one full period behind. Service with a zero or at-least-half
//   period: catch-up adder loop, one period addition per cycle, 65535 at most.
//   Reset clears all timer state and min_delay and empties the output
//   register. A stalled receiver holds the result, and the block then stops
//   accepting after it has finished the next transaction.
// ----------------------------------------------------------------------------
module periodic_match_timer_with_catchup import pmt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  mode_i,
  input  logic [31:0] counter_i,
  input  logic [30:0] delay_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] time_now_o,
  output logic [31:0] match_out_o,
  output logic        timer_on_o,
  output logic        match_pending_o,
  output logic [15:0] catchup_steps_o
);

  pmt_cmd_t    cmd;
  pmt_status_t status;

  pmt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  pmt_dpath u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .mode_i          (mode_i),
    .counter_i       (counter_i),
    .delay_i         (delay_i),
    .cmd_i           (cmd),
    .status_o        (status),
    .time_now_o      (time_now_o),
    .match_out_o     (match_out_o),
    .timer_on_o      (timer_on_o),
    .match_pending_o (match_pending_o),
    .catchup_steps_o (catchup_steps_o)
  );

endmodule
